[src/fnd_pkg.sv]
`default_nettype none

package fnd_pkg;

	// Field widths of the item, the result and the reference register.
	localparam int unsigned TGT_W  = 33;
	localparam int unsigned REF_W  = 27;
	localparam int unsigned INT_W  = 16;
	localparam int unsigned MOD_W  = 12;
	localparam int unsigned K_W    = 3;
	localparam int unsigned BAND_W = 8;
	localparam int unsigned ST_W   = 2;

	// Divider and sequencer sizing.
	localparam int unsigned DIV_STEPS = TGT_W;
	localparam int unsigned CNT_W     = $clog2(DIV_STEPS);
	localparam int unsigned PC_W      = 4;

	localparam int unsigned MODULUS_MAX_DEF = 4095;

	// Frequency plan constants; the frequencies among them are in Hz.
	localparam logic [TGT_W-1:0]  VCO_LOW_HZ     = 33'd2200000000;
	localparam logic [TGT_W-1:0]  VCO_HIGH_HZ    = 33'd4400000000;
	localparam logic [TGT_W-1:0]  PRESC_SPLIT_HZ = 33'd3000000000;
	localparam logic [REF_W-1:0]  BAND_CLK_HZ    = 27'd125000;
	localparam logic [REF_W-1:0]  BAND_ROUND_HZ  = 27'd124999;
	localparam logic [REF_W-1:0]  REF_RESET_HZ   = 27'd10000000;
	localparam logic [TGT_W-1:0]  INT_MIN_LOW    = 33'd23;
	localparam logic [TGT_W-1:0]  INT_MIN_HIGH   = 33'd75;
	localparam logic [TGT_W-1:0]  INT_MAX        = 33'd65535;
	localparam logic [K_W-1:0]    K_MAX          = 3'd4;
	localparam logic [TGT_W-1:0]  BAND_SAT_FROM  = 33'd254;
	localparam logic [BAND_W-1:0] BAND_SAT       = 8'd255;

	// Result status codes.
	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_INT   = 2'd2,
		ST_FRAC  = 2'd3
	} status_t;

	// Datapath operations, one per control word.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_DIV_BAND,
		OP_BAND_SET,
		OP_SCALE,
		OP_PRESCALE,
		OP_DIV_REF,
		OP_SEARCH_INIT,
		OP_SEARCH_STEP,
		OP_FINISH,
		OP_FAIL_RANGE,
		OP_FAIL_INT,
		OP_EMIT
	} opcode_t;

	// Jump conditions.
	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_ITEM,
		C_DIV_MORE,
		C_TGT_BAD,
		C_NEED_SCALE,
		C_VCO_LOW,
		C_REF_ZERO,
		C_INT_BAD,
		C_HALF,
		C_SEARCH_GO,
		C_OUT_BUSY
	} cond_t;

	// One control word: the operation, a jump condition and its target.
	// With gate set, the operation runs only while the condition holds.
	typedef struct packed {
		opcode_t         op;
		cond_t           cond;
		logic            gate;
		logic [PC_W-1:0] target;
	} ucode_t;

	// Control of the shared divide unit.
	typedef struct packed {
		logic load;
		logic step;
	} div_ctrl_t;

	// Program addresses.
	localparam logic [PC_W-1:0] PC_WAIT        = 4'd0;
	localparam logic [PC_W-1:0] PC_BAND_DIV    = 4'd1;
	localparam logic [PC_W-1:0] PC_BAND_SET    = 4'd2;
	localparam logic [PC_W-1:0] PC_SCALE       = 4'd3;
	localparam logic [PC_W-1:0] PC_PRESCALE    = 4'd4;
	localparam logic [PC_W-1:0] PC_REF_CHECK   = 4'd5;
	localparam logic [PC_W-1:0] PC_REF_DIV     = 4'd6;
	localparam logic [PC_W-1:0] PC_SEARCH_INIT = 4'd7;
	localparam logic [PC_W-1:0] PC_MOD_TWO     = 4'd8;
	localparam logic [PC_W-1:0] PC_HALF_CHECK  = 4'd9;
	localparam logic [PC_W-1:0] PC_MOD_THREE   = 4'd10;
	localparam logic [PC_W-1:0] PC_SEARCH      = 4'd11;
	localparam logic [PC_W-1:0] PC_FINISH      = 4'd12;
	localparam logic [PC_W-1:0] PC_FAIL_RANGE  = 4'd13;
	localparam logic [PC_W-1:0] PC_FAIL_INT    = 4'd14;
	localparam logic [PC_W-1:0] PC_EMIT        = 4'd15;

	function automatic ucode_t uw(input opcode_t op, input cond_t cond, input logic gate,
			input logic [PC_W-1:0] target);
		ucode_t w;
		w.op     = op;
		w.cond   = cond;
		w.gate   = gate;
		w.target = target;
		return w;
	endfunction

	// The planning program. The last step falls through to the wait step.
	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
		ucode_t w;
		case (pc)
			PC_WAIT:        w = uw(OP_LOAD,        C_NO_ITEM,    1'b0, PC_WAIT);
			PC_BAND_DIV:    w = uw(OP_DIV_BAND,    C_DIV_MORE,   1'b0, PC_BAND_DIV);
			PC_BAND_SET:    w = uw(OP_BAND_SET,    C_TGT_BAD,    1'b0, PC_FAIL_RANGE);
			PC_SCALE:       w = uw(OP_SCALE,       C_NEED_SCALE, 1'b1, PC_SCALE);
			PC_PRESCALE:    w = uw(OP_PRESCALE,    C_VCO_LOW,    1'b0, PC_FAIL_RANGE);
			PC_REF_CHECK:   w = uw(OP_NONE,        C_REF_ZERO,   1'b0, PC_FAIL_INT);
			PC_REF_DIV:     w = uw(OP_DIV_REF,     C_DIV_MORE,   1'b0, PC_REF_DIV);
			PC_SEARCH_INIT: w = uw(OP_SEARCH_INIT, C_INT_BAD,    1'b0, PC_FAIL_INT);
			PC_MOD_TWO:     w = uw(OP_SEARCH_STEP, C_NEVER,      1'b0, PC_WAIT);
			PC_HALF_CHECK:  w = uw(OP_NONE,        C_HALF,       1'b0, PC_FINISH);
			PC_MOD_THREE:   w = uw(OP_SEARCH_STEP, C_NEVER,      1'b0, PC_WAIT);
			PC_SEARCH:      w = uw(OP_SEARCH_STEP, C_SEARCH_GO,  1'b1, PC_SEARCH);
			PC_FINISH:      w = uw(OP_FINISH,      C_ALWAYS,     1'b0, PC_EMIT);
			PC_FAIL_RANGE:  w = uw(OP_FAIL_RANGE,  C_ALWAYS,     1'b0, PC_EMIT);
			PC_FAIL_INT:    w = uw(OP_FAIL_INT,    C_NEVER,      1'b0, PC_WAIT);
			PC_EMIT:        w = uw(OP_EMIT,        C_OUT_BUSY,   1'b0, PC_EMIT);
			default:        w = uw(OP_NONE,        C_ALWAYS,     1'b0, PC_WAIT);
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

[src/fnd_divider.sv]
`default_nettype none

// Restoring divider, one quotient bit per step. The quotient shifts into
// the dividend register; both results hold while neither load nor step is set.
module fnd_divider (
	input  wire logic                     clk,
	input  wire fnd_pkg::div_ctrl_t       ctrl,
	input  wire logic [fnd_pkg::TGT_W-1:0] dividend,
	input  wire logic [fnd_pkg::REF_W-1:0] divisor,
	output logic      [fnd_pkg::TGT_W-1:0] quotient,
	output logic      [fnd_pkg::REF_W-1:0] remainder
);

	logic [fnd_pkg::TGT_W-1:0] dd_q;
	logic [fnd_pkg::REF_W-1:0] dr_q;
	logic [fnd_pkg::REF_W:0]   trial;
	logic [fnd_pkg::REF_W:0]   diff;
	logic                      fits;

	// Trial subtraction of the divisor from the partial remainder.
	always_comb begin
		trial = {dr_q, dd_q[fnd_pkg::TGT_W-1]};
		diff  = trial - {1'b0, divisor};
		fits  = (trial >= {1'b0, divisor});
	end

	// Load or advance one bit.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			dd_q <= dividend;
			dr_q <= '0;
		end else if (ctrl.step) begin
			dd_q <= {dd_q[fnd_pkg::TGT_W-2:0], fits};
			dr_q <= fits ? diff[fnd_pkg::REF_W-1:0] : trial[fnd_pkg::REF_W-1:0];
		end
	end

	assign quotient  = dd_q;
	assign remainder = dr_q;

endmodule

`default_nettype wire

[src/fractional_n_divider_planner.sv]
// Throughput: one item at a time; the next item is taken only after the result
//   is registered. A target out of band fails before the reference divide and
//   the modulus search. The work is the modulus trial loop, one modulus per cycle,
//   and two 33-step passes through the shared divider.
// Reset: arst_n clears the sequencer, the output valid and sets the reference to 10 MHz.
`default_nettype none

module fractional_n_divider_planner #(
	parameter int unsigned MODULUS_MAX = fnd_pkg::MODULUS_MAX_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,

	input  wire logic                       cfg_wr_en,
	input  wire logic [fnd_pkg::REF_W-1:0]  cfg_wr_data,

	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [fnd_pkg::TGT_W-1:0]  target_frequency_hz,

	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic      [fnd_pkg::INT_W-1:0]  integer_divide,
	output logic      [fnd_pkg::MOD_W-1:0]  fraction_numerator,
	output logic      [fnd_pkg::MOD_W-1:0]  modulus,
	output logic      [fnd_pkg::K_W-1:0]    output_divider_select,
	output logic                            prescaler_select,
	output logic                            lock_detect_function,
	output logic      [fnd_pkg::BAND_W-1:0] band_select_clock_div,
	output logic      [fnd_pkg::ST_W-1:0]   status
);

	localparam logic [fnd_pkg::MOD_W-1:0] MOD_LAST = fnd_pkg::MOD_W'(MODULUS_MAX);

	// Control state.
	logic [fnd_pkg::REF_W-1:0] ref_q;
	logic [fnd_pkg::PC_W-1:0]  pc_q;
	logic [fnd_pkg::CNT_W-1:0] cnt_q;
	logic                      out_valid_q;

	// Datapath registers.
	logic [fnd_pkg::TGT_W-1:0] vco_q;
	logic [fnd_pkg::K_W-1:0]   k_q;
	logic                      pre_q;
	logic [fnd_pkg::BAND_W-1:0] band_q;
	logic [fnd_pkg::MOD_W-1:0] mod_q;
	logic [fnd_pkg::MOD_W-1:0] q_q;
	logic [fnd_pkg::REF_W-1:0] r_q;

	// Result staging registers.
	logic [fnd_pkg::INT_W-1:0] res_int_q;
	logic [fnd_pkg::MOD_W-1:0] res_frac_q;
	logic [fnd_pkg::MOD_W-1:0] res_mod_q;
	logic [fnd_pkg::K_W-1:0]   res_k_q;
	logic                      res_pre_q;
	logic                      res_lock_q;
	fnd_pkg::status_t          res_status_q;

	// Output registers.
	logic [fnd_pkg::INT_W-1:0]  int_out_q;
	logic [fnd_pkg::MOD_W-1:0]  frac_out_q;
	logic [fnd_pkg::MOD_W-1:0]  mod_out_q;
	logic [fnd_pkg::K_W-1:0]    k_out_q;
	logic                       pre_out_q;
	logic                       lock_out_q;
	logic [fnd_pkg::BAND_W-1:0] band_out_q;
	fnd_pkg::status_t           status_out_q;

	fnd_pkg::ucode_t           ucode;
	fnd_pkg::div_ctrl_t        div_ctrl;
	logic [fnd_pkg::TGT_W-1:0] div_dividend;
	logic [fnd_pkg::REF_W-1:0] div_divisor;
	logic [fnd_pkg::TGT_W-1:0] div_quot;
	logic [fnd_pkg::REF_W-1:0] div_rem;

	logic                      tgt_bad, need_scale, vco_low, ref_zero, int_bad;
	logic                      half, search_go, out_busy, div_more;
	logic                      cond_true, run_op, emit_fire;
	logic [fnd_pkg::TGT_W-1:0] int_min;
	logic [fnd_pkg::REF_W:0]   r_sum;
	logic                      r_wrap;
	logic [fnd_pkg::REF_W-1:0] r_next;
	logic                      round_up;
	logic [fnd_pkg::MOD_W:0]   frac_sum;
	logic [fnd_pkg::BAND_W-1:0] band_val;

	// Fetch the control word of the current step.
	assign ucode = fnd_pkg::ucode_rom(pc_q);

	// Datapath flags that the program tests.
	always_comb begin
		tgt_bad    = (vco_q == '0) || (vco_q > fnd_pkg::VCO_HIGH_HZ);
		vco_low    = (vco_q < fnd_pkg::VCO_LOW_HZ);
		need_scale = vco_low && (k_q < fnd_pkg::K_MAX);
		ref_zero   = (ref_q == '0);
		int_min    = pre_q ? fnd_pkg::INT_MIN_HIGH : fnd_pkg::INT_MIN_LOW;
		int_bad    = (div_quot > fnd_pkg::INT_MAX) || (div_quot < int_min);
		half       = (r_q == '0) && (q_q == fnd_pkg::MOD_W'(1));
		search_go  = (r_q != '0) && (mod_q != MOD_LAST);
		out_busy   = out_valid_q && out_stall;
		div_more   = (cnt_q != fnd_pkg::CNT_W'(fnd_pkg::DIV_STEPS - 1));
	end

	// Evaluate the jump condition.
	always_comb begin
		case (ucode.cond)
			fnd_pkg::C_NEVER:      cond_true = 1'b0;
			fnd_pkg::C_ALWAYS:     cond_true = 1'b1;
			fnd_pkg::C_NO_ITEM:    cond_true = !in_valid;
			fnd_pkg::C_DIV_MORE:   cond_true = div_more;
			fnd_pkg::C_TGT_BAD:    cond_true = tgt_bad;
			fnd_pkg::C_NEED_SCALE: cond_true = need_scale;
			fnd_pkg::C_VCO_LOW:    cond_true = vco_low;
			fnd_pkg::C_REF_ZERO:   cond_true = ref_zero;
			fnd_pkg::C_INT_BAD:    cond_true = int_bad;
			fnd_pkg::C_HALF:       cond_true = half;
			fnd_pkg::C_SEARCH_GO:  cond_true = search_go;
			fnd_pkg::C_OUT_BUSY:   cond_true = out_busy;
			default:               cond_true = 1'b0;
		endcase
		run_op    = !ucode.gate || cond_true;
		emit_fire = (ucode.op == fnd_pkg::OP_EMIT) && !out_busy;
	end

	// Shared divider: first the band clock divide, then the reference divide.
	always_comb begin
		div_ctrl.load = (ucode.op == fnd_pkg::OP_LOAD) || (ucode.op == fnd_pkg::OP_PRESCALE);
		div_ctrl.step = (ucode.op == fnd_pkg::OP_DIV_BAND) || (ucode.op == fnd_pkg::OP_DIV_REF);
		div_dividend  = (ucode.op == fnd_pkg::OP_PRESCALE) ? vco_q :
			fnd_pkg::TGT_W'(ref_q) + fnd_pkg::TGT_W'(fnd_pkg::BAND_ROUND_HZ);
		div_divisor   = (ucode.op == fnd_pkg::OP_DIV_REF) ? ref_q : fnd_pkg::BAND_CLK_HZ;
	end

	fnd_divider u_divider (
		.clk       (clk),
		.ctrl      (div_ctrl),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	// Next modulus: add the remainder to the running product and fold it once.
	always_comb begin
		r_sum  = {1'b0, r_q} + {1'b0, div_rem};
		r_wrap = (r_sum >= {1'b0, ref_q});
		r_next = r_wrap ? fnd_pkg::REF_W'(r_sum - {1'b0, ref_q}) : r_sum[fnd_pkg::REF_W-1:0];
	end

	// Rounded numerator and saturated band clock divider.
	always_comb begin
		round_up = ({r_q, 1'b0} >= {1'b0, ref_q});
		frac_sum = {1'b0, q_q} + fnd_pkg::MOD_W'(round_up);
		band_val = (div_quot >= fnd_pkg::BAND_SAT_FROM) ? fnd_pkg::BAND_SAT :
			div_quot[fnd_pkg::BAND_W-1:0] + fnd_pkg::BAND_W'(1);
	end

	// Sequencer, divide step counter, reference register and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= fnd_pkg::PC_WAIT;
			cnt_q       <= '0;
			ref_q       <= fnd_pkg::REF_RESET_HZ;
			out_valid_q <= 1'b0;
		end else begin
			pc_q <= cond_true ? ucode.target : pc_q + fnd_pkg::PC_W'(1);
			if (div_ctrl.load) begin
				cnt_q <= '0;
			end else if (div_ctrl.step) begin
				cnt_q <= cnt_q + fnd_pkg::CNT_W'(1);
			end
			if (cfg_wr_en) begin
				ref_q <= cfg_wr_data;
			end
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath operations.
	always_ff @(posedge clk) begin
		if (run_op) begin
			case (ucode.op)
				fnd_pkg::OP_LOAD: begin
					vco_q <= target_frequency_hz;
					k_q   <= '0;
				end
				fnd_pkg::OP_BAND_SET: begin
					band_q <= band_val;
				end
				fnd_pkg::OP_SCALE: begin
					vco_q <= {vco_q[fnd_pkg::TGT_W-2:0], 1'b0};
					k_q   <= k_q + fnd_pkg::K_W'(1);
				end
				fnd_pkg::OP_PRESCALE: begin
					pre_q <= (vco_q >= fnd_pkg::PRESC_SPLIT_HZ);
				end
				fnd_pkg::OP_SEARCH_INIT: begin
					mod_q <= fnd_pkg::MOD_W'(1);
					q_q   <= '0;
					r_q   <= div_rem;
				end
				fnd_pkg::OP_SEARCH_STEP: begin
					mod_q <= mod_q + fnd_pkg::MOD_W'(1);
					q_q   <= q_q + fnd_pkg::MOD_W'(r_wrap);
					r_q   <= r_next;
				end
				fnd_pkg::OP_FINISH: begin
					res_int_q    <= div_quot[fnd_pkg::INT_W-1:0];
					res_frac_q   <= frac_sum[fnd_pkg::MOD_W-1:0];
					res_mod_q    <= mod_q;
					res_k_q      <= k_q;
					res_pre_q    <= pre_q;
					res_lock_q   <= (frac_sum == '0);
					res_status_q <= (frac_sum >= {1'b0, mod_q}) ? fnd_pkg::ST_FRAC :
						fnd_pkg::ST_OK;
				end
				fnd_pkg::OP_FAIL_RANGE: begin
					res_int_q    <= '0;
					res_frac_q   <= '0;
					res_mod_q    <= '0;
					res_k_q      <= '0;
					res_pre_q    <= 1'b0;
					res_lock_q   <= 1'b0;
					res_status_q <= fnd_pkg::ST_RANGE;
				end
				fnd_pkg::OP_FAIL_INT: begin
					res_int_q    <= '0;
					res_frac_q   <= '0;
					res_mod_q    <= '0;
					res_k_q      <= k_q;
					res_pre_q    <= pre_q;
					res_lock_q   <= 1'b0;
					res_status_q <= fnd_pkg::ST_INT;
				end
				default: begin
				end
			endcase
		end
	end

	// Output register, loaded when the previous result has been taken.
	always_ff @(posedge clk) begin
		if (emit_fire) begin
			int_out_q    <= res_int_q;
			frac_out_q   <= res_frac_q;
			mod_out_q    <= res_mod_q;
			k_out_q      <= res_k_q;
			pre_out_q    <= res_pre_q;
			lock_out_q   <= res_lock_q;
			band_out_q   <= band_q;
			status_out_q <= res_status_q;
		end
	end

	assign in_stall              = (pc_q != fnd_pkg::PC_WAIT);
	assign out_valid             = out_valid_q;
	assign integer_divide        = int_out_q;
	assign fraction_numerator    = frac_out_q;
	assign modulus               = mod_out_q;
	assign output_divider_select = k_out_q;
	assign prescaler_select      = pre_out_q;
	assign lock_detect_function  = lock_out_q;
	assign band_select_clock_div = band_out_q;
	assign status                = status_out_q;

	// A new result appears only after the emit step.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(pc_q) == fnd_pkg::PC_EMIT)
		else $error("result raised outside the emit step");

	// The search always finishes with a modulus between two and the limit.
	assert property (@(posedge clk) disable iff (!arst_n)
		pc_q == fnd_pkg::PC_FINISH |-> (mod_q >= fnd_pkg::MOD_W'(2)) && (mod_q <= MOD_LAST))
		else $error("modulus outside the search range at finish");

	// An ok result has a proper fraction.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_out_q == fnd_pkg::ST_OK) |-> frac_out_q < mod_out_q)
		else $error("numerator not below modulus in an ok result");

	// A range failure carries an empty plan.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_out_q == fnd_pkg::ST_RANGE) |->
			(int_out_q == '0) && (mod_out_q == '0) && (k_out_q == '0) && !lock_out_q)
		else $error("range failure with a nonzero plan");

	// Lock detect follows the numerator on a completed plan.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && ((status_out_q == fnd_pkg::ST_OK) || (status_out_q == fnd_pkg::ST_FRAC))
			|-> lock_out_q == (frac_out_q == '0))
		else $error("lock detect does not match the numerator");

endmodule

`default_nettype wire
